// File: hdl/set_assoc_cache_controller_macros.svh
// Assertion helpers for the cache controller.
`ifndef SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH
`define SET_ASSOC_CACHE_CONTROLLER_MACROS_SVH

// Same-cycle implication.
`define SACC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sacc same-cycle check failed");

// Next-cycle implication.
`define SACC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sacc next-cycle check failed");

`endif

// File: hdl/sacc_pkg.sv
package sacc_pkg;

  localparam int SETS      = 64;
  localparam int WAYS      = 4;
  localparam int WPL       = 4;
  localparam int ADDR_BITS = 32;
  localparam int WORD_W    = 32;
  localparam int TAG_W     = 24;
  localparam int OFF_W     = 2;
  localparam int SET_W     = 6;
  localparam int WAY_W     = 2;
  localparam int RANK_W    = 2;
  localparam int CNT_W     = 3;
  localparam int ITEMS     = 3;
  localparam int ITEM_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_STATUS    = 2'd0,
    OP_MEM_READ  = 2'd1,
    OP_MEM_WRITE = 2'd2
  } mem_op_t;

  localparam logic [1:0] CFG_WRITE_POLICY = 2'd0;
  localparam logic [1:0] CFG_ALLOC_POLICY = 2'd1;
  localparam logic [1:0] CFG_REPL_POLICY  = 2'd2;
  localparam logic [1:0] CFG_WAYS_IN_USE  = 2'd3;

  localparam logic       WP_BACK    = 1'b0;
  localparam logic       WP_THROUGH = 1'b1;
  localparam logic [1:0] ALLOC_READ  = 2'd0;
  localparam logic [1:0] ALLOC_WRITE = 2'd1;
  localparam logic [1:0] ALLOC_BOTH  = 2'd2;
  localparam logic [1:0] REPL_LRU    = 2'd0;
  localparam logic [1:0] REPL_MRU    = 2'd1;
  localparam logic [1:0] REPL_RAND   = 2'd2;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef logic [WPL-1:0][WORD_W-1:0] line_t;

  typedef struct packed {
    logic              wp;
    logic [1:0]        ap;
    logic [1:0]        rp;
    logic [CNT_W-1:0]  wiu;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [ADDR_BITS-1:0] addr;
    line_t               words;
    logic [CNT_W-1:0]    cnt;
    logic                hit;
    logic                ev;
    logic [TAG_W-1:0]    etag;
    logic                last;
  } item_t;

  typedef struct packed {
    logic rd;
    logic upd;
  } ctl_cmd_t;

  typedef struct packed {
    logic buf_empty;
  } ctl_sts_t;

  function automatic item_t mk_item(logic [1:0] op, logic [ADDR_BITS-1:0] addr,
                                    line_t words, logic [CNT_W-1:0] cnt);
    item_t it;
    it = '0;
    it.op   = op;
    it.addr = addr;
    it.cnt  = cnt;
    for (int i = 0; i < WPL; i++) begin
      it.words[i] = (CNT_W'(i) < cnt) ? words[i] : '0;
    end
    return it;
  endfunction

  function automatic logic [1:0] mod3(logic [15:0] x);
    logic [4:0] s;
    logic [2:0] s2;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (s2 >= 3'd6) s2 = s2 - 3'd6;
    else if (s2 >= 3'd3) s2 = s2 - 3'd3;
    return s2[1:0];
  endfunction

endpackage

// File: hdl/sacc_ctrl.sv
`include "set_assoc_cache_controller_macros.svh"
module sacc_ctrl import sacc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_LOOKUP = 2'b10
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);
  assign cmd.rd   = in_valid && in_ready;
  assign cmd.upd  = (state == S_LOOKUP) && sts.buf_empty;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd.rd) state_next = S_LOOKUP;
      S_LOOKUP: if (cmd.upd) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `SACC_ASSERT_NXT(a_rd_to_lookup, cmd.rd, state == S_LOOKUP)
  `SACC_ASSERT_NXT(a_upd_to_idle, cmd.upd, state == S_IDLE)
  `SACC_ASSERT_NXT(a_hold_on_busy, (state == S_LOOKUP) && !sts.buf_empty, state == S_LOOKUP)

endmodule

// File: hdl/sacc_dpath.sv
module sacc_dpath import sacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  input  cfg_t                  cfg,
  input  logic                  req_type,
  input  logic [ADDR_BITS-1:0]  req_address,
  input  logic [4:0]            req_size,
  input  line_t                 in_words,
  output item_t                 items [ITEMS],
  output logic [ITEM_IDX_W-1:0] item_count
);

  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
  typedef logic [WAYS-1:0][WPL-1:0][WORD_W-1:0] data_row_t;
  typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

  tag_row_t  tag_mem   [SETS];
  data_row_t data_mem  [SETS];
  logic [WAYS-1:0] dirty_mem [SETS];
  rank_row_t rank_mem  [SETS];
  logic [WAYS-1:0] valid [SETS];
  logic [15:0] lfsr;

  logic                 q_wr;
  logic [ADDR_BITS-1:0] q_addr;
  logic [4:0]           q_size;
  line_t                q_wd;
  tag_row_t  tag_row;
  data_row_t data_row;
  logic [WAYS-1:0] dirty_row;
  rank_row_t rank_row;

  logic [SET_W-1:0] set;
  logic [OFF_W-1:0] off;
  logic [TAG_W-1:0] tag;
  logic [WAYS-1:0]  vrow;
  logic [3:0]       n_raw;
  logic [CNT_W-1:0] n, m, room, cnt, limit;
  logic             hit, alloc, do_new, do_evict, has_free, rfound, bfound;
  logic [WAY_W-1:0] hit_way, free_way, rway, best, victim, way_sel;
  logic [15:0]      lfsr_step;
  logic [1:0]       target;
  logic [RANK_W-1:0] r;
  tag_row_t  tag_new;
  data_row_t data_new;
  logic [WAYS-1:0] dirty_new, valid_new;
  rank_row_t rank_new;
  line_t     line, masked_rd;
  logic [ITEM_IDX_W-1:0] k;

  assign set  = q_addr[SET_W+OFF_W-1:OFF_W];
  assign off  = q_addr[OFF_W-1:0];
  assign tag  = q_addr[ADDR_BITS-1:SET_W+OFF_W];
  assign vrow = valid[set];

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      q_wr      <= req_type;
      q_addr    <= req_address;
      q_size    <= req_size;
      q_wd      <= in_words;
      tag_row   <= tag_mem[req_address[SET_W+OFF_W-1:OFF_W]];
      data_row  <= data_mem[req_address[SET_W+OFF_W-1:OFF_W]];
      dirty_row <= dirty_mem[req_address[SET_W+OFF_W-1:OFF_W]];
      rank_row  <= rank_mem[req_address[SET_W+OFF_W-1:OFF_W]];
    end
    if (cmd.upd) begin
      tag_mem[set]   <= tag_new;
      data_mem[set]  <= data_new;
      dirty_mem[set] <= dirty_new;
      rank_mem[set]  <= rank_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SETS; i++) valid[i] <= '0;
      lfsr <= LFSR_SEED;
    end else if (cmd.upd) begin
      valid[set] <= valid_new;
      if (do_evict && cfg.rp == REPL_RAND) lfsr <= lfsr_step;
    end
  end

  always_comb begin
    n_raw = 4'((6'(q_size) + 6'd3) >> 2);
    n     = (n_raw > 4'(WPL)) ? CNT_W'(WPL) : n_raw[CNT_W-1:0];
    room  = CNT_W'(WPL) - CNT_W'(off);
    m     = (n < room) ? n : room;

    hit = 1'b0; hit_way = '0; has_free = 1'b0; free_way = '0; cnt = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (vrow[i] && tag_row[i] == tag) begin
        hit = 1'b1; hit_way = WAY_W'(i);
      end
      if (!vrow[i]) begin
        has_free = 1'b1; free_way = WAY_W'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) cnt = cnt + CNT_W'(vrow[i]);

    limit = (cfg.wiu == '0) ? CNT_W'(1) :
            (cfg.wiu > CNT_W'(WAYS)) ? CNT_W'(WAYS) : cfg.wiu;
    alloc = cfg.ap == ALLOC_BOTH || (cfg.ap == ALLOC_READ && !q_wr) ||
            (cfg.ap == ALLOC_WRITE && q_wr);
    do_new   = !hit && alloc && cnt < limit && has_free;
    do_evict = !hit && alloc && !do_new;

    lfsr_step = lfsr >> 1;
    if (lfsr[0]) lfsr_step = lfsr_step ^ LFSR_TAPS;
    case (cnt)
      3'd2:    target = {1'b0, lfsr_step[0]};
      3'd3:    target = mod3(lfsr_step);
      3'd4:    target = lfsr_step[1:0];
      default: target = 2'd0;
    endcase

    rfound = 1'b0; rway = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (vrow[i] && rank_row[i] == target) begin
        rfound = 1'b1; rway = WAY_W'(i);
      end
    end
    bfound = 1'b0; best = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (vrow[i]) begin
        if (!bfound) begin
          bfound = 1'b1; best = WAY_W'(i);
        end else if (cfg.rp == REPL_MRU ? rank_row[i] < rank_row[best]
                                        : rank_row[i] > rank_row[best]) begin
          best = WAY_W'(i);
        end
      end
    end
    victim  = (cfg.rp == REPL_RAND && rfound) ? rway : best;
    way_sel = hit ? hit_way : (do_new ? free_way : victim);

    rank_new = rank_row;
    r = rank_row[way_sel];
    if ((hit && cfg.rp != REPL_RAND) || do_evict) begin
      for (int i = 0; i < WAYS; i++)
        if (vrow[i] && rank_row[i] < r) rank_new[i] = rank_row[i] + 1'b1;
      rank_new[way_sel] = '0;
    end else if (do_new) begin
      for (int i = 0; i < WAYS; i++)
        if (vrow[i]) rank_new[i] = rank_row[i] + 1'b1;
      rank_new[way_sel] = '0;
    end

    valid_new = vrow;
    tag_new   = tag_row;
    dirty_new = dirty_row;
    if (do_new || do_evict) begin
      valid_new[way_sel] = 1'b1;
      tag_new[way_sel]   = tag;
      dirty_new[way_sel] = q_wr && cfg.wp == WP_BACK;
    end else if (hit && q_wr) begin
      dirty_new[way_sel] = cfg.wp == WP_BACK;
    end

    line = data_row[way_sel];
    if (do_new || do_evict) line = '0;
    if (q_wr && (hit || alloc)) begin
      for (int i = 0; i < WPL; i++)
        if (CNT_W'(i) < m) line[off + OFF_W'(i)] = q_wd[i];
    end
    data_new = data_row;
    data_new[way_sel] = line;

    for (int i = 0; i < WPL; i++)
      masked_rd[i] = data_row[hit_way][off + OFF_W'(i)];

    for (int i = 0; i < ITEMS; i++) items[i] = '0;
    items[0] = mk_item(OP_STATUS, q_addr, masked_rd, (hit && !q_wr) ? m : '0);
    items[0].hit  = hit;
    items[0].ev   = do_evict;
    items[0].etag = do_evict ? tag_row[victim] : '0;
    k = ITEM_IDX_W'(1);
    if (do_evict && dirty_row[victim]) begin
      items[k] = mk_item(OP_MEM_WRITE, {tag_row[victim], set, OFF_W'(0)},
                         data_row[victim], CNT_W'(WPL));
      k = k + 1'b1;
    end
    if ((hit || alloc) && q_wr && cfg.wp == WP_THROUGH) begin
      items[k] = mk_item(OP_MEM_WRITE, q_addr, q_wd, m);
      k = k + 1'b1;
    end else if (!hit && !q_wr) begin
      items[k] = mk_item(OP_MEM_READ, q_addr, '0, CNT_W'(WPL));
      k = k + 1'b1;
    end else if (!hit && !alloc) begin
      items[k] = mk_item(OP_MEM_WRITE, q_addr, q_wd, n);
      k = k + 1'b1;
    end
    items[k - 1'b1].last = 1'b1;
    item_count = k;
  end

endmodule

// File: hdl/sacc_emit.sv
module sacc_emit import sacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  item_t                 items [ITEMS],
  input  logic [ITEM_IDX_W-1:0] item_count,
  output ctl_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output item_t                 out_item
);

  item_t                 pend [ITEMS];
  logic [ITEM_IDX_W-1:0] left, idx;

  assign out_valid     = (left != '0);
  assign out_item      = pend[idx];
  assign sts.buf_empty = (left == '0);

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < ITEMS; i++) pend[i] <= items[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      idx  <= '0;
    end else if (load) begin
      left <= item_count;
      idx  <= '0;
    end else if (out_valid && out_ready) begin
      left <= left - 1'b1;
      idx  <= idx + 1'b1;
    end
  end

endmodule

// File: hdl/set_assoc_cache_controller.sv
// 4-way set-associative cache controller, 64 sets, 4-word lines.
// Input channel s_*: one request per beat; s_tuser is the request type
// (read or write), s_tdata carries address, size and four write words.
// Output channel m_*: each request yields 1 to 3 beats. The first beat is the
// status (hit, eviction, evicted tag, read data); following beats are memory
// requests (dirty write-back first, then fill read or forwarded write).
// m_tlast marks the final beat of a request; m_tuser is the memory op.
// Config channel cfg_*: register index and data; always ready. Write only
// while no request is in flight.
// Flow: a request is handled in two steps, a tag/data/state row read when the
// request beat is taken and a row update that loads the result buffer, from
// which the first beat is driven. The next request is accepted while earlier
// result beats still drain, and the update waits until the result buffer is empty.
// Reset: synchronous; clears valid bits, LFSR and config to defaults. If the
// receiver stalls, beats hold and at most one further request is taken.
module set_assoc_cache_controller import sacc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [167:0] s_tdata,  // req_address, req_size, in_word0..3, zero pad
  input  logic         s_tuser,  // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,  // mem_address, out_word0..3, word_count, hit, evicted,
                                 // victim tag, zero pad
  output logic [1:0]   m_tuser,  // mem_op
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [2:0]   cfg_data
);

  cfg_t                  cfg;
  ctl_cmd_t              cmd;
  ctl_sts_t              sts;
  item_t                 items [ITEMS];
  logic [ITEM_IDX_W-1:0] item_count;
  item_t                 out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wp  <= WP_BACK;
      cfg.ap  <= ALLOC_BOTH;
      cfg.rp  <= REPL_LRU;
      cfg.wiu <= CNT_W'(WAYS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WRITE_POLICY: cfg.wp  <= cfg_data[0];
        CFG_ALLOC_POLICY: cfg.ap  <= cfg_data[1:0];
        CFG_REPL_POLICY:  cfg.rp  <= cfg_data[1:0];
        CFG_WAYS_IN_USE:  cfg.wiu <= cfg_data;
        default: ;
      endcase
    end
  end

  sacc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .req_type    (s_tuser),
    .req_address (s_tdata[31:0]),
    .req_size    (s_tdata[36:32]),
    .in_words    (s_tdata[164:37]),
    .items       (items),
    .item_count  (item_count)
  );

  sacc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (cmd.upd),
    .items      (items),
    .item_count (item_count),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_item   (out_item)
  );

  assign m_tdata = {3'b000, out_item.etag, out_item.ev, out_item.hit, out_item.cnt,
                    out_item.words, out_item.addr};
  assign m_tuser = out_item.op;
  assign m_tlast = out_item.last;

endmodule

// File: bench/tb.sv
module tb;
  import sacc_pkg::*;

  typedef struct {
    mem_op_t           op;
    logic [31:0]       addr;
    logic [3:0][31:0]  words;
    logic [2:0]        cnt;
    logic              hit;
    logic              ev;
    logic [23:0]       etag;
    logic              last;
  } beat_t;

  typedef struct {
    bit          wr;
    logic [31:0] a;
    logic [4:0]  sz;
    logic [31:0] w0, w1, w2, w3;
    int          pin_hit;
  } req_row_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [191:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = CFG_WRITE_POLICY;
  logic [2:0]   cfg_data = '0;

  set_assoc_cache_controller dut (.*);

  always #5 clk = ~clk;

  logic [23:0] tag_mem [SETS*WAYS];
  logic        vld_mem [SETS*WAYS];
  logic        dirty_mem [SETS*WAYS];
  logic [1:0]  rank_mem [SETS*WAYS];
  logic [2:0]  fill_mem [SETS];
  logic [31:0] word_mem [SETS*WAYS*WPL];
  logic [15:0] lfsr;
  logic        wp_q;
  logic [1:0]  ap_q, rp_q;
  logic [2:0]  wiu_q;

  beat_t pending_beats[$];
  int    errors = 0;
  int    cycles = 0;
  int    idle_mode = 0;
  int    phase_no = 0;
  bit    hold_done = 0;
  int    hold_cnt = 0;

  function automatic beat_t mk_beat(mem_op_t op, logic [31:0] a, logic [3:0][31:0] w,
                                    int cnt);
    beat_t b;
    b.op = op;
    b.addr = a;
    for (int i = 0; i < 4; i++) b.words[i] = (i < cnt) ? w[i] : 32'h0;
    b.cnt = cnt[2:0];
    b.hit = 0;
    b.ev = 0;
    b.etag = '0;
    b.last = 0;
    return b;
  endfunction

  function automatic void bump_rank(int base, int way);
    logic [1:0] r;
    r = rank_mem[base+way];
    for (int i = 0; i < WAYS; i++)
      if (vld_mem[base+i] && rank_mem[base+i] < r) rank_mem[base+i]++;
    rank_mem[base+way] = 0;
  endfunction

  function automatic int choose_victim(int base, int cnt);
    int best, target;
    best = WAYS;
    if (rp_q == REPL_RAND) begin
      if (lfsr[0]) lfsr = (lfsr >> 1) ^ LFSR_TAPS;
      else lfsr = lfsr >> 1;
      target = cnt ? lfsr % cnt : 0;
      for (int i = 0; i < WAYS; i++)
        if (vld_mem[base+i] && rank_mem[base+i] == target) return i;
    end
    for (int i = 0; i < WAYS; i++) begin
      if (!vld_mem[base+i]) continue;
      if (best == WAYS) best = i;
      else if (rp_q == REPL_MRU ? rank_mem[base+i] < rank_mem[base+best]
                                : rank_mem[base+i] > rank_mem[base+best]) best = i;
    end
    return best == WAYS ? 0 : best;
  endfunction

  function automatic void predict_request(bit wr, logic [31:0] a, logic [4:0] sz,
                                          logic [3:0][31:0] wd, output logic hit_o);
    beat_t st, mem_q[$];
    logic [3:0][31:0] rd, ln;
    int n, m, off, set, base, way, cnt, limit, freew, rdcnt;
    logic [23:0] tag, etag;
    bit ev, alloc;
    rd = '0;
    rdcnt = 0;
    ev = 0;
    etag = '0;
    hit_o = 0;
    n = (int'(sz) + 3) / 4;
    if (n > WPL) n = WPL;
    off = a[1:0];
    set = a[7:2];
    tag = a[31:8];
    base = set * WAYS;
    m = (n > WPL - off) ? WPL - off : n;
    way = WAYS;
    for (int i = 0; i < WAYS; i++)
      if (vld_mem[base+i] && tag_mem[base+i] == tag) begin
        way = i;
        break;
      end
    if (way < WAYS) begin
      hit_o = 1;
      if (rp_q != REPL_RAND) bump_rank(base, way);
      if (!wr) begin
        for (int i = 0; i < m; i++) rd[i] = word_mem[(base+way)*WPL + off + i];
        rdcnt = m;
      end else begin
        for (int i = 0; i < m; i++) word_mem[(base+way)*WPL + off + i] = wd[i];
        dirty_mem[base+way] = (wp_q == WP_BACK);
        if (wp_q == WP_THROUGH) mem_q = {mem_q, mk_beat(OP_MEM_WRITE, a, wd, m)};
      end
    end else begin
      alloc = ap_q == ALLOC_BOTH || (ap_q == ALLOC_READ && !wr) || (ap_q == ALLOC_WRITE && wr);
      if (alloc) begin
        limit = wiu_q == 0 ? 1 : (wiu_q > WAYS ? WAYS : wiu_q);
        cnt = fill_mem[set];
        freew = WAYS;
        for (int i = 0; i < WAYS; i++)
          if (!vld_mem[base+i]) begin
            freew = i;
            break;
          end
        if (cnt < limit && freew < WAYS) begin
          way = freew;
          for (int i = 0; i < WAYS; i++) if (vld_mem[base+i]) rank_mem[base+i]++;
          rank_mem[base+way] = 0;
          fill_mem[set]++;
        end else begin
          way = choose_victim(base, cnt);
          ev = 1;
          etag = tag_mem[base+way];
          if (dirty_mem[base+way]) begin
            for (int i = 0; i < WPL; i++) ln[i] = word_mem[(base+way)*WPL + i];
            mem_q = {mem_q, mk_beat(OP_MEM_WRITE, {etag, set[5:0], 2'b00}, ln, WPL)};
          end
          bump_rank(base, way);
        end
        vld_mem[base+way] = 1;
        tag_mem[base+way] = tag;
        for (int i = 0; i < WPL; i++) word_mem[(base+way)*WPL + i] = 0;
        if (wr) begin
          for (int i = 0; i < m; i++) word_mem[(base+way)*WPL + off + i] = wd[i];
          dirty_mem[base+way] = (wp_q == WP_BACK);
          if (wp_q == WP_THROUGH) mem_q = {mem_q, mk_beat(OP_MEM_WRITE, a, wd, m)};
        end else begin
          dirty_mem[base+way] = 0;
          mem_q = {mem_q, mk_beat(OP_MEM_READ, a, '0, WPL)};
        end
      end else if (wr) begin
        mem_q = {mem_q, mk_beat(OP_MEM_WRITE, a, wd, n)};
      end else begin
        mem_q = {mem_q, mk_beat(OP_MEM_READ, a, '0, WPL)};
      end
    end
    st = mk_beat(OP_STATUS, a, rd, rdcnt);
    st.hit = hit_o;
    st.ev = ev;
    st.etag = etag;
    if (mem_q.size() == 0) st.last = 1;
    else mem_q[mem_q.size()-1].last = 1;
    pending_beats = {pending_beats, st};
    foreach (mem_q[i]) pending_beats = {pending_beats, mem_q[i]};
  endfunction

  task automatic wait_idle_cycles(int k);
    repeat (k) @(negedge clk);
  endtask

  task automatic send_request(req_row_t r);
    logic [3:0][31:0] wd;
    logic h;
    wd = {r.w3, r.w2, r.w1, r.w0};
    if ((idle_mode == 1 && $urandom_range(99) < 72) ||
        (idle_mode == 3 && $urandom_range(99) < 30)) begin
      s_tvalid <= 0;
      wait_idle_cycles($urandom_range(1, 4));
    end
    s_tvalid <= 1;
    s_tuser  <= r.wr;
    s_tdata  <= {3'b0, r.w3, r.w2, r.w1, r.w0, r.sz, r.a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(r.wr, r.a, r.sz, wd, h);
    if (r.pin_hit >= 0 && h !== r.pin_hit[0]) begin
      $error("hit: expected %0d actual %0d", r.pin_hit, h);
      errors++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending_beats.size() != 0) @(negedge clk);
    wait_idle_cycles(8);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_WRITE_POLICY: wp_q = val[0];
      CFG_ALLOC_POLICY: ap_q = val[1:0];
      CFG_REPL_POLICY:  rp_q = val[1:0];
      default:          wiu_q = val;
    endcase
    @(negedge clk);
  endtask

  function automatic req_row_t random_request();
    req_row_t r;
    r.wr = $urandom_range(1);
    if ($urandom_range(99) < 85)
      r.a = {$urandom_range(5) == 5 ? 24'($urandom) : 24'($urandom_range(5)),
             6'($urandom_range(3)), 2'($urandom_range(3))};
    else
      r.a = $urandom;
    r.sz = $urandom_range(99) < 80 ? 5'($urandom_range(16)) : 5'($urandom_range(31));
    r.w0 = $urandom;
    r.w1 = $urandom;
    r.w2 = $urandom;
    r.w3 = $urandom;
    r.pin_hit = -1;
    return r;
  endfunction

  always @(negedge clk) begin
    if (phase_no == 4 && !hold_done) begin
      hold_done <= 1;
      hold_cnt <= 300;
      m_tready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 0;
    end else if (idle_mode == 2) begin
      m_tready <= $urandom_range(99) >= 72;
    end else if (idle_mode == 3) begin
      m_tready <= $urandom_range(99) >= 30;
    end else begin
      m_tready <= 1;
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat addr %h", m_tdata[31:0]);
        errors++;
      end else begin
        e = pending_beats.pop_front();
        if (m_tuser !== e.op) begin
          $error("mem_op: expected %0d actual %0d", e.op, m_tuser); errors++;
        end
        if (m_tdata[31:0] !== e.addr) begin
          $error("mem_address: expected %h actual %h", e.addr, m_tdata[31:0]); errors++;
        end
        for (int i = 0; i < 4; i++)
          if (m_tdata[32+32*i +: 32] !== e.words[i]) begin
            $error("out_word%0d: expected %h actual %h", i, e.words[i],
                   m_tdata[32+32*i +: 32]);
            errors++;
          end
        if (m_tdata[162:160] !== e.cnt) begin
          $error("word_count: expected %0d actual %0d", e.cnt, m_tdata[162:160]); errors++;
        end
        if (m_tdata[163] !== e.hit) begin
          $error("hit: expected %0d actual %0d", e.hit, m_tdata[163]); errors++;
        end
        if (m_tdata[164] !== e.ev) begin
          $error("evicted: expected %0d actual %0d", e.ev, m_tdata[164]); errors++;
        end
        if (m_tdata[188:165] !== e.etag) begin
          $error("victim_tag: expected %h actual %h", e.etag, m_tdata[188:165]); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  localparam logic [31:0] S1 = 32'h0000_0004;
  req_row_t directed_rows[] = '{
    '{0, 32'h0000_0000, 16, 0, 0, 0, 0, 0},
    '{0, 32'h0000_0000, 16, 0, 0, 0, 0, 1},
    '{1, 32'h0000_0001, 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1},
    '{0, 32'h0000_0000, 31, 0, 0, 0, 0, 1},
    '{1, 32'h0000_0003, 0, 32'h1234_5678, 0, 0, 0, 1},
    '{0, 32'h0000_0002, 0, 0, 0, 0, 0, 1},
    '{0, 32'hFFFF_FFFF, 4, 0, 0, 0, 0, 0},
    '{1, 32'hFFFF_FFFE, 16, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'hFFFF_FFFF, 1},
    '{0, 32'hFFFF_FFFC, 16, 0, 0, 0, 0, 1},
    '{1, S1 | 32'h100, 16, 32'h11, 32'h12, 32'h13, 32'h14, 0},
    '{1, S1 | 32'h200, 8, 32'h21, 32'h22, 32'h23, 32'h24, 0},
    '{1, S1 | 32'h300, 4, 32'h31, 32'h32, 32'h33, 32'h34, 0},
    '{0, S1 | 32'h400, 4, 0, 0, 0, 0, 0},
    '{1, S1 | 32'h500, 12, 32'h51, 32'h52, 32'h53, 32'h54, 0},
    '{0, S1 | 32'h201, 16, 0, 0, 0, 0, 1},
    '{0, S1 | 32'h100, 16, 0, 0, 0, 0, 0},
    '{1, S1 | 32'h300, 16, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0},
    '{0, S1 | 32'h600, 1, 0, 0, 0, 0, 0}
  };

  int phase_cfg [8][4] = '{
    '{0, 2, 0, 4}, '{1, 0, 1, 2}, '{0, 1, 2, 3}, '{1, 3, 3, 0},
    '{0, 2, 2, 7}, '{0, 0, 0, 1}, '{1, 2, 1, 5}, '{0, 2, 0, 4}
  };

  initial begin
    for (int i = 0; i < SETS*WAYS; i++) begin
      vld_mem[i] = 0; dirty_mem[i] = 0; rank_mem[i] = 0; tag_mem[i] = '0;
    end
    for (int i = 0; i < SETS; i++) fill_mem[i] = 0;
    for (int i = 0; i < SETS*WAYS*WPL; i++) word_mem[i] = 0;
    lfsr = LFSR_SEED;
    wp_q = WP_BACK; ap_q = ALLOC_BOTH; rp_q = REPL_LRU; wiu_q = 3'd4;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    foreach (directed_rows[i]) send_request(directed_rows[i]);
    for (int p = 0; p < 8; p++) begin
      drain();
      phase_no = p;
      idle_mode = p % 4;
      write_reg(CFG_WRITE_POLICY, 3'(phase_cfg[p][0]));
      write_reg(CFG_ALLOC_POLICY, 3'(phase_cfg[p][1]));
      write_reg(CFG_REPL_POLICY, 3'(phase_cfg[p][2]));
      write_reg(CFG_WAYS_IN_USE, 3'(phase_cfg[p][3]));
      cfg_valid <= 0;
      repeat (24) send_request(random_request());
    end
    drain();
    wait_idle_cycles(20);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
